>>> rtl/srsw_pkg.sv
// srsw_pkg: shared types, codes and default sizes for the selective-repeat
// sender window. No dependencies; imported by the interfaces and all modules.
`timescale 1ns / 1ps

package srsw_pkg;

  localparam int BUF_DEPTH_DEF    = 8;
  localparam int SEQ_BITS_DEF     = 8;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam int WLEN_W  = 4;
  localparam int SEQ_W   = 8;
  localparam int PAY_W   = 64;

  // item kinds
  localparam logic [1:0] KIND_SEND    = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  // timer requests
  localparam logic [1:0] TMR_NONE    = 2'd0;
  localparam logic [1:0] TMR_START   = 2'd1;
  localparam logic [1:0] TMR_STOP    = 2'd2;
  localparam logic [1:0] TMR_RESTART = 2'd3;

  // ack verdicts
  localparam logic [2:0] ACK_NONE    = 3'd0;
  localparam logic [2:0] ACK_CORRUPT = 3'd1;
  localparam logic [2:0] ACK_BASE    = 3'd2;
  localparam logic [2:0] ACK_OOO     = 3'd3;
  localparam logic [2:0] ACK_IGNORED = 3'd4;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 4'd4;

  typedef struct packed {
    logic [1:0]       kind;
    logic [PAY_W-1:0] payload;
    logic [SEQ_W-1:0] seq_in;
    logic             ack_checksum_ok;
  } in_item_t;

  typedef struct packed {
    logic             accepted;
    logic             tx_valid;
    logic [SEQ_W-1:0] tx_seq;
    logic [PAY_W-1:0] tx_payload;
    logic [1:0]       timer_cmd;
    logic [SEQ_W-1:0] timer_seq;
    logic [2:0]       ack_result;
    logic             waiting;
    logic [SEQ_W-1:0] window_base;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SLIDE,
    ST_READ,
    ST_EMIT
  } state_t;

endpackage

>>> rtl/srsw_ifs.sv
// srsw_ifs: valid/ready channel interfaces for input and result items.
// Depends on srsw_pkg for the item structs.
`timescale 1ns / 1ps

interface srsw_in_if import srsw_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface srsw_out_if import srsw_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

>>> rtl/srsw_ring.sv
// srsw_ring: ring buffer memory holding sequence number and payload per slot,
// one write port, one read port with registered read data. Uses srsw_pkg.
`timescale 1ns / 1ps

module srsw_ring import srsw_pkg::*; #(
  parameter int DEPTH = BUF_DEPTH_DEF,
  parameter int WIDTH = SEQ_BITS_DEF + PAYLOAD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/selective_repeat_sender_window_top.sv
// selective_repeat_sender_window_top: sender window sequencer with ack bits,
// window counters and result register. Uses srsw_pkg, srsw_ifs, srsw_ring.
`timescale 1ns / 1ps

// Selective-repeat sender window.
// in_ch carries send, ack and timeout items; out_ch returns one result item
// for each input item: transmit request, timer request, ack verdict, and the
// waiting flag and window base after the item. cfg_we/cfg_wdata write the
// window length; the user must write it only while the block is idle, which
// the block itself does not enforce. One item at a time: in_ch.ready is
// high only while the sequencer is idle. A send, ack or ignored item passes
// through a decode state and an emit state before its result is registered.
// A timeout that resends adds a read state for the registered ring read. An
// ack for the window base adds slide states that step over each acknowledged
// entry in turn, then a final check.
// Reset (synchronous, rst_n low) empties the window: base and next sequence
// at 0, all ack bits clear, waiting low, window length 4. Ring contents need
// no clearing since only outstanding entries are ever read.
// While out_ch stalls, one finished result waits in the output register and
// the next item is still taken and worked on; it then holds in its emit
// cycle until the output register frees.

module selective_repeat_sender_window_top import srsw_pkg::*; #(
  parameter int BUF_DEPTH    = BUF_DEPTH_DEF,
  parameter int SEQ_BITS     = SEQ_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [WLEN_W-1:0] cfg_wdata,
  srsw_in_if.sink           in_ch,
  srsw_out_if.source        out_ch
);

  localparam int SW     = $clog2(BUF_DEPTH);
  localparam int HALF   = 2 ** (SEQ_BITS - 1);
  localparam int CAP    = (BUF_DEPTH < HALF) ? BUF_DEPTH : HALF;
  localparam int MEM_W  = SEQ_BITS + PAYLOAD_BITS;

  state_t state_r, state_nxt;

  logic [SEQ_BITS-1:0]     base_r, base_nxt;
  logic [SEQ_BITS-1:0]     next_r, next_nxt;
  logic                    wait_r, wait_nxt;
  logic [SW-1:0]           bslot_r, bslot_nxt;
  logic [BUF_DEPTH-1:0]    acked_r;
  logic [WLEN_W-1:0]       wlen_r;

  logic [1:0]              kind_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [SEQ_BITS-1:0]     seq_r;
  logic                    ck_r;

  out_item_t               res_r, res_nxt;
  out_item_t               out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_load;

  logic                    ack_we;
  logic [SW-1:0]           ack_idx;
  logic                    ack_val;

  logic                    mem_we;
  logic [SW-1:0]           mem_wa;
  logic [SW-1:0]           mem_ra;
  logic [MEM_W-1:0]        mem_rd;

  logic [SEQ_BITS-1:0]     outstanding;
  logic [SEQ_BITS-1:0]     off;
  logic [SEQ_BITS-1:0]     wl_ext;
  logic [SEQ_BITS-1:0]     weff;
  logic [SEQ_BITS-1:0]     slot_off;
  logic [SW:0]             slot_sum;
  logic [SW-1:0]           slot;

  srsw_ring #(
    .DEPTH (BUF_DEPTH),
    .WIDTH (MEM_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data ({next_r, pay_r}),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  // window arithmetic, all offsets taken from the base
  always_comb begin
    outstanding = next_r - base_r;
    off         = seq_r - base_r;
    wl_ext      = SEQ_BITS'(wlen_r);
    if (wl_ext > SEQ_BITS'(CAP)) begin
      weff = SEQ_BITS'(CAP);
    end else if (wl_ext == '0) begin
      weff = SEQ_BITS'(1);
    end else begin
      weff = wl_ext;
    end
    // shared slot adder: offset is below BUF_DEPTH whenever the slot is used
    slot_off = (kind_r == KIND_SEND) ? outstanding : off;
    slot_sum = (SW+1)'(bslot_r) + (SW+1)'(slot_off);
    if (slot_sum >= (SW+1)'(BUF_DEPTH)) begin
      slot = SW'(slot_sum - (SW+1)'(BUF_DEPTH));
    end else begin
      slot = SW'(slot_sum);
    end
  end

  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    next_nxt      = next_r;
    wait_nxt      = wait_r;
    bslot_nxt     = bslot_r;
    res_nxt       = res_r;
    ack_we        = 1'b0;
    ack_idx       = slot;
    ack_val       = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = slot;
    mem_ra        = slot;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          res_nxt   = '0;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_EMIT;
        unique case (kind_r)
          KIND_SEND: begin
            if (!wait_r && outstanding < weff) begin
              mem_we             = 1'b1;
              ack_we             = 1'b1;
              ack_val            = 1'b0;
              res_nxt.accepted   = 1'b1;
              res_nxt.tx_valid   = 1'b1;
              res_nxt.tx_seq     = SEQ_W'(next_r);
              res_nxt.tx_payload = PAY_W'(pay_r);
              res_nxt.timer_cmd  = TMR_START;
              res_nxt.timer_seq  = SEQ_W'(next_r);
              next_nxt           = next_r + SEQ_BITS'(1);
              if (outstanding + SEQ_BITS'(1) == weff) begin
                wait_nxt = 1'b1;
              end
            end
          end
          KIND_ACK: begin
            priority if (!ck_r) begin
              res_nxt.ack_result = ACK_CORRUPT;
            end else if (off == '0 && outstanding != '0) begin
              ack_we             = 1'b1;
              ack_idx            = bslot_r;
              ack_val            = 1'b1;
              res_nxt.timer_cmd  = TMR_STOP;
              res_nxt.timer_seq  = SEQ_W'(seq_r);
              res_nxt.ack_result = ACK_BASE;
              state_nxt          = ST_SLIDE;
            end else if (off != '0 && off < outstanding && !acked_r[slot]) begin
              ack_we             = 1'b1;
              ack_val            = 1'b1;
              res_nxt.timer_cmd  = TMR_STOP;
              res_nxt.timer_seq  = SEQ_W'(seq_r);
              res_nxt.ack_result = ACK_OOO;
            end else begin
              res_nxt.ack_result = ACK_IGNORED;
            end
          end
          KIND_TIMEOUT: begin
            if (off < outstanding && !acked_r[slot]) begin
              res_nxt.tx_valid  = 1'b1;
              res_nxt.timer_cmd = TMR_RESTART;
              res_nxt.timer_seq = SEQ_W'(seq_r);
              state_nxt         = ST_READ;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SLIDE: begin
        // one acknowledged entry leaves the window per cycle
        if (outstanding != '0 && acked_r[bslot_r]) begin
          ack_we    = 1'b1;
          ack_idx   = bslot_r;
          ack_val   = 1'b0;
          bslot_nxt = (bslot_r == SW'(BUF_DEPTH - 1)) ? '0 : bslot_r + SW'(1);
          base_nxt  = base_r + SEQ_BITS'(1);
        end else begin
          wait_nxt  = 1'b0;
          state_nxt = ST_EMIT;
        end
      end
      ST_READ: begin
        res_nxt.tx_seq     = SEQ_W'(mem_rd[MEM_W-1:PAYLOAD_BITS]);
        res_nxt.tx_payload = PAY_W'(mem_rd[PAYLOAD_BITS-1:0]);
        state_nxt          = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result item with the window state after the item
  always_comb begin
    out_nxt             = res_r;
    out_nxt.waiting     = wait_r;
    out_nxt.window_base = SEQ_W'(base_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      next_r      <= '0;
      wait_r      <= 1'b0;
      bslot_r     <= '0;
      acked_r     <= '0;
      wlen_r      <= WLEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      wait_r      <= wait_nxt;
      bslot_r     <= bslot_nxt;
      out_valid_r <= out_valid_nxt;
      if (ack_we) begin
        acked_r[ack_idx] <= ack_val;
      end
      if (cfg_we) begin
        wlen_r <= cfg_wdata;
      end
    end
  end

  // item and result payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      kind_r <= in_ch.item.kind;
      pay_r  <= PAYLOAD_BITS'(in_ch.item.payload);
      seq_r  <= SEQ_BITS'(in_ch.item.seq_in);
      ck_r   <= in_ch.item.ack_checksum_ok;
    end
    res_r <= res_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.item  = out_r;

endmodule

>>> sim/srsw_tb_pkg.sv
// srsw_tb_pkg: scoreboard for the selective-repeat sender window testbench.
// Keeps its own copy of the window state and predicts one result per item.
// Depends on srsw_pkg for the item structs and codes.
`timescale 1ns / 1ps

package srsw_tb_pkg;
  import srsw_pkg::*;

  // no-operation kind, not named in the design package
  localparam logic [1:0] KIND_NOP = 2'd3;

  class window_scoreboard;
    logic [SEQ_W-1:0]  base;
    logic [SEQ_W-1:0]  next_seq;
    logic              waiting;
    logic [WLEN_W-1:0] wlen;
    int                base_slot;
    logic              acked [BUF_DEPTH_DEF];
    logic [PAY_W-1:0]  pay_store [BUF_DEPTH_DEF];
    logic [SEQ_W-1:0]  seq_store [BUF_DEPTH_DEF];
    out_item_t         pending_results [$];
    int mismatches, n_items, n_sent, n_refused, n_slides, n_ooo, n_resent;

    function new();
      base      = '0;
      next_seq  = '0;
      waiting   = 1'b0;
      wlen      = WLEN_RESET;
      base_slot = 0;
      foreach (acked[i]) begin
        acked[i]     = 1'b0;
        pay_store[i] = '0;
        seq_store[i] = '0;
      end
      mismatches = 0;
      n_items    = 0;
      n_sent     = 0;
      n_refused  = 0;
      n_slides   = 0;
      n_ooo      = 0;
      n_resent   = 0;
    endfunction

    function void set_window(logic [WLEN_W-1:0] v);
      wlen = v;
    endfunction

    function int outstanding();
      logic [SEQ_W-1:0] d;
      d = next_seq - base;
      return int'(d);
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    // window is clipped to the ring depth and half the sequence space
    function int window_size();
      int w;
      w = int'(wlen);
      if (w > BUF_DEPTH_DEF) w = BUF_DEPTH_DEF;
      if (w > (1 << (SEQ_W - 1))) w = 1 << (SEQ_W - 1);
      if (w < 1) w = 1;
      return w;
    endfunction

    function int slot_at(int off);
      return (base_slot + off) % BUF_DEPTH_DEF;
    endfunction

    function void note_input(in_item_t it);
      out_item_t        r;
      int               outst, w, s, n;
      logic [SEQ_W-1:0] off;
      r     = '0;
      outst = outstanding();
      off   = it.seq_in - base;
      n_items++;
      case (it.kind)
        KIND_SEND: begin
          w = window_size();
          if (!waiting && outst < w) begin
            s = slot_at(outst);
            pay_store[s] = it.payload;
            seq_store[s] = next_seq;
            acked[s]     = 1'b0;
            r.accepted   = 1'b1;
            r.tx_valid   = 1'b1;
            r.tx_seq     = next_seq;
            r.tx_payload = it.payload;
            r.timer_cmd  = TMR_START;
            r.timer_seq  = next_seq;
            next_seq     = next_seq + 1'b1;
            if (outst + 1 == w) waiting = 1'b1;
            n_sent++;
          end else begin
            n_refused++;
          end
        end
        KIND_ACK: begin
          if (!it.ack_checksum_ok) begin
            r.ack_result = ACK_CORRUPT;
          end else if (off == 0 && outst > 0) begin
            r.timer_cmd = TMR_STOP;
            r.timer_seq = it.seq_in;
            acked[base_slot] = 1'b1;
            // slide over the run of acknowledged entries
            for (n = 0; n < BUF_DEPTH_DEF && outst > 0 && acked[base_slot]; n++) begin
              acked[base_slot] = 1'b0;
              base_slot = (base_slot + 1) % BUF_DEPTH_DEF;
              base      = base + 1'b1;
              outst--;
            end
            waiting      = 1'b0;
            r.ack_result = ACK_BASE;
            n_slides++;
          end else if (off > 0 && off < outst && !acked[slot_at(off)]) begin
            acked[slot_at(off)] = 1'b1;
            r.timer_cmd  = TMR_STOP;
            r.timer_seq  = it.seq_in;
            r.ack_result = ACK_OOO;
            n_ooo++;
          end else begin
            r.ack_result = ACK_IGNORED;
          end
        end
        KIND_TIMEOUT: begin
          if (off < outst && !acked[slot_at(off)]) begin
            s = slot_at(off);
            r.tx_valid   = 1'b1;
            r.tx_seq     = seq_store[s];
            r.tx_payload = pay_store[s];
            r.timer_cmd  = TMR_RESTART;
            r.timer_seq  = it.seq_in;
            n_resent++;
          end
        end
        default: begin
        end
      endcase
      r.waiting     = waiting;
      r.window_base = base;
      pending_results.push_back(r);
    endfunction

    function void report(string what, out_item_t e, out_item_t g);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: exp acc=%0b txv=%0b txseq=%0h txpay=%h tcmd=%0d tseq=%0h ack=%0d wait=%0b base=%0h",
                 what, e.accepted, e.tx_valid, e.tx_seq, e.tx_payload, e.timer_cmd,
                 e.timer_seq, e.ack_result, e.waiting, e.window_base);
        $display("%s: got acc=%0b txv=%0b txseq=%0h txpay=%h tcmd=%0d tseq=%0h ack=%0d wait=%0b base=%0h",
                 what, g.accepted, g.tx_valid, g.tx_seq, g.tx_payload, g.timer_cmd,
                 g.timer_seq, g.ack_result, g.waiting, g.window_base);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending_results.size() == 0) begin
        report("unexpected result", '0, got);
      end else begin
        e = pending_results.pop_front();
        if (got !== e) report("result mismatch", e, got);
      end
    endfunction
  endclass

endpackage

>>> sim/tb.sv
// tb: self-checking bench for selective_repeat_sender_window_top.
// Directed window cases, then random send/ack/timeout traffic under varying
// handshake idling, checked against the scoreboard in srsw_tb_pkg.
`timescale 1ns / 1ps

module tb;
  import srsw_pkg::*;
  import srsw_tb_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 6;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [WLEN_W-1:0] cfg_wdata = '0;

  int tx_idle_pct = 16;
  int rx_idle_pct = 66;
  int rx_hold_left = 0;

  window_scoreboard sb = new();

  srsw_in_if  in_ch ();
  srsw_out_if out_ch ();

  selective_repeat_sender_window_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // result side: check what was taken, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.item);
    if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("no progress for %0d cycles", STALL_LIMIT);
    $display("selective_repeat_sender_window_top test failed");
    $finish;
  end

  function automatic in_item_t mk_item(logic [1:0] k, logic [PAY_W-1:0] p,
                                       logic [SEQ_W-1:0] s, logic ok);
    in_item_t it;
    it.kind            = k;
    it.payload         = p;
    it.seq_in          = s;
    it.ack_checksum_ok = ok;
    return it;
  endfunction

  // mostly well-formed traffic aimed at outstanding entries, some noise
  function automatic in_item_t make_traffic_item();
    in_item_t it;
    int r, outst, sel;
    outst = sb.outstanding();
    r     = $urandom_range(0, 99);
    sel   = $urandom_range(0, 9);
    it.kind            = KIND_NOP;
    it.payload         = {$urandom, $urandom};
    it.seq_in          = SEQ_W'($urandom_range(0, 255));
    it.ack_checksum_ok = ($urandom_range(0, 19) != 0);
    if (r < 4) begin
      it.ack_checksum_ok = ($urandom_range(0, 1) != 0);
    end else if (r < (sb.waiting ? 20 : 48)) begin
      it.kind = KIND_SEND;
      if (sel == 0) it.payload = '0;
      else if (sel == 1) it.payload = '1;
    end else if (r < 80) begin
      it.kind = KIND_ACK;
      if (sel >= 1 && sel < 5) it.seq_in = sb.base;
      else if (sel >= 5) it.seq_in = sb.base + SEQ_W'($urandom_range(0, outst));
    end else begin
      it.kind = KIND_TIMEOUT;
      if (sel > 1) it.seq_in = sb.base + SEQ_W'($urandom_range(0, outst > 0 ? outst - 1 : 0));
    end
    return it;
  endfunction

  task automatic drive_item(input in_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
  endtask

  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    while (sb.pending_count() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WLEN_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_window(v);
  endtask

  task automatic run_traffic(input int n);
    in_item_t it;
    int cnt;
    cnt = 0;
    while (cnt < n) begin
      it = make_traffic_item();
      if (it.kind != KIND_NOP) cnt++;
      drive_item(it);
    end
    finish_phase();
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.item   = '0;
    out_ch.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty window, then fill the reset window of 4 and unwind it
    drive_item(mk_item(KIND_ACK, '0, 8'h00, 1'b1));
    drive_item(mk_item(KIND_TIMEOUT, '0, 8'h00, 1'b1));
    drive_item(mk_item(KIND_NOP, '1, 8'hff, 1'b1));
    drive_item(mk_item(KIND_ACK, '0, 8'h00, 1'b0));
    drive_item(mk_item(KIND_SEND, '0, 8'h00, 1'b0));
    drive_item(mk_item(KIND_SEND, '1, 8'hff, 1'b1));
    drive_item(mk_item(KIND_SEND, {$urandom, $urandom}, 8'h00, 1'b0));
    drive_item(mk_item(KIND_SEND, {$urandom, $urandom}, 8'h00, 1'b0));
    drive_item(mk_item(KIND_SEND, {$urandom, $urandom}, 8'h00, 1'b0));
    drive_item(mk_item(KIND_ACK, '0, 8'h02, 1'b1));
    drive_item(mk_item(KIND_ACK, '0, 8'h02, 1'b1));
    drive_item(mk_item(KIND_ACK, '0, 8'h04, 1'b1));
    drive_item(mk_item(KIND_TIMEOUT, '0, 8'h02, 1'b1));
    drive_item(mk_item(KIND_TIMEOUT, '0, 8'h01, 1'b1));
    drive_item(mk_item(KIND_ACK, '0, 8'h01, 1'b1));
    drive_item(mk_item(KIND_ACK, '0, 8'h00, 1'b1));
    drive_item(mk_item(KIND_ACK, '0, 8'hff, 1'b1));
    drive_item(mk_item(KIND_TIMEOUT, '0, 8'h03, 1'b1));
    drive_item(mk_item(KIND_ACK, '0, 8'h03, 1'b1));
    finish_phase();

    // window of one, then widened while waiting
    write_window(4'd1);
    drive_item(mk_item(KIND_SEND, {$urandom, $urandom}, 8'h00, 1'b1));
    drive_item(mk_item(KIND_SEND, {$urandom, $urandom}, 8'h00, 1'b1));
    finish_phase();
    write_window(4'd8);
    drive_item(mk_item(KIND_SEND, {$urandom, $urandom}, 8'h00, 1'b1));
    drive_item(mk_item(KIND_ACK, '0, 8'h04, 1'b1));
    repeat (5) drive_item(mk_item(KIND_SEND, {$urandom, $urandom}, 8'h00, 1'b1));
    finish_phase();

    // window shrunk below what is outstanding
    write_window(4'd2);
    drive_item(mk_item(KIND_SEND, {$urandom, $urandom}, 8'h00, 1'b1));
    drive_item(mk_item(KIND_ACK, '0, 8'h05, 1'b1));
    finish_phase();

    write_window(4'd8);
    run_traffic(250);
    write_window(4'd3);
    run_traffic(100);

    tx_idle_pct = 66;
    rx_idle_pct = 16;
    write_window(4'd1);
    run_traffic(120);
    write_window(4'd6);
    run_traffic(130);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_window(4'd8);
    rx_hold_left = HOLD_CYCLES;
    run_traffic(150);
    write_window(4'd4);
    run_traffic(150);

    $display("%0d items: %0d sends taken, %0d refused, %0d resends",
             sb.n_items, sb.n_sent, sb.n_refused, sb.n_resent);
    $display("%0d base slides, %0d out-of-order acks, window lengths 1 to 8, %0d mismatches",
             sb.n_slides, sb.n_ooo, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("selective_repeat_sender_window_top test passed");
    end else begin
      $display("selective_repeat_sender_window_top test failed");
    end
    $finish;
  end

endmodule

>>> selective_repeat_sender_window_top.f
rtl/srsw_pkg.sv
rtl/srsw_ifs.sv
rtl/srsw_ring.sv
rtl/selective_repeat_sender_window_top.sv
sim/srsw_tb_pkg.sv
sim/tb.sv
